[rtl/der_tag_length_decoder_assert.svh]
// Assertion macros for the DER tag-length decoder.
// Used by the top level; needs nothing else.
`ifndef DER_TAG_LENGTH_DECODER_ASSERT_SVH
`define DER_TAG_LENGTH_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dtl_pkg.sv]
// Shared types and constants for the DER tag-length decoder.
// No dependencies.
package dtl_pkg;

    localparam int DTL_MAX_TAG_OCTETS    = 4;
    localparam int DTL_MAX_LENGTH_OCTETS = 8;

    localparam int BYTE_W  = 8;
    localparam int AVAIL_W = 32;
    localparam int TAG_W   = 32;
    localparam int LEN_W   = 64;
    localparam int HDR_W   = 4;
    localparam int STAT_W  = 3;

    localparam int S_TDATA_W = BYTE_W + AVAIL_W;                       // 40
    localparam int M_FIELD_W = TAG_W + LEN_W + HDR_W;                  // 100
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;              // 104

    localparam logic [4:0] TAG_NUM_ESC   = 5'h1F;  // low five bits all ones
    localparam logic [7:0] LEN_INDEF     = 8'h80;
    localparam logic [7:0] LEN_RESERVED  = 8'hFF;
    localparam int         TAG_NUM_MIN   = 31;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TAG_FIRST = 3'd1,
        PH_TAG_MORE  = 3'd2,
        PH_LEN_FIRST = 3'd3,
        PH_LEN_MORE  = 3'd4
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_TAG = 3'd1,
        ST_BAD_LEN = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_OVERRUN = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               start_req;
        logic [AVAIL_W-1:0] available;
    } t_in_beat;

    typedef struct packed {
        logic [TAG_W-1:0] tag_value;
        logic [LEN_W-1:0] content_length;
        logic [HDR_W-1:0] header_octets;
        t_status          status;
    } t_result;

endpackage

[rtl/dtl_in_reg.sv]
// Input register stage: captures one octet beat and holds it until the parser takes it.
// Depends on dtl_pkg.
module dtl_in_reg
    import dtl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

[rtl/dtl_parser.sv]
// Header parser: phase, tag and length accumulators, one octet per step.
// Depends on dtl_pkg.
module dtl_parser
    import dtl_pkg::*;
#(
    parameter int MAX_TAG_OCTETS    = DTL_MAX_TAG_OCTETS,
    parameter int MAX_LENGTH_OCTETS = DTL_MAX_LENGTH_OCTETS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_beat i_beat,
    output logic     o_emit,
    output t_result  o_result
);

    // tag number only needs the groups after the first octet
    localparam int TNW = 7 * (MAX_TAG_OCTETS - 1);

    t_phase             r_phase,  n_phase;
    logic [TAG_W-1:0]   r_tag,    n_tag;
    logic [TNW-1:0]     r_tnum,   n_tnum;
    logic [HDR_W-1:0]   r_cnt,    n_cnt;
    logic [LEN_W-1:0]   r_len,    n_len;
    logic [3:0]         r_left,   n_left;
    logic [AVAIL_W-1:0] r_buf,    n_buf;

    // state as seen after a start beat has reset it
    t_phase             e_phase;
    logic [TAG_W-1:0]   e_tag;
    logic [TNW-1:0]     e_tnum;
    logic [HDR_W-1:0]   e_cnt;
    logic [LEN_W-1:0]   e_len;
    logic [3:0]         e_left;
    logic [AVAIL_W-1:0] e_buf;

    logic [BYTE_W-1:0]  b;
    logic [HDR_W-1:0]   cnt1;
    logic [TNW-1:0]     tnum_sh;
    logic [LEN_W-1:0]   len_sh;
    logic [3:0]         left1;
    logic [LEN_W-1:0]   fin_len;
    logic [AVAIL_W-1:0] room;
    logic               do_finish;
    logic               emit;
    t_status            stat;

    always_comb begin
        b       = i_beat.data_byte;
        e_phase = i_beat.start_req ? PH_TAG_FIRST : r_phase;
        e_tag   = i_beat.start_req ? '0 : r_tag;
        e_tnum  = i_beat.start_req ? '0 : r_tnum;
        e_cnt   = i_beat.start_req ? '0 : r_cnt;
        e_len   = i_beat.start_req ? '0 : r_len;
        e_left  = i_beat.start_req ? '0 : r_left;
        e_buf   = i_beat.start_req ? i_beat.available : r_buf;

        cnt1    = e_cnt + HDR_W'(1);
        tnum_sh = TNW'({e_tnum, b[6:0]});
        len_sh  = {e_len[LEN_W-9:0], b};
        left1   = (e_left != 4'd0) ? (e_left - 4'd1) : 4'd0;
        room    = e_buf - AVAIL_W'(cnt1);

        n_phase   = e_phase;
        n_tag     = e_tag;
        n_tnum    = e_tnum;
        n_cnt     = e_cnt;
        n_len     = e_len;
        n_left    = e_left;
        n_buf     = e_buf;
        emit      = 1'b0;
        stat      = ST_OK;
        do_finish = 1'b0;
        fin_len   = len_sh;

        if (e_phase != PH_IDLE) begin
            if (AVAIL_W'(e_cnt) >= e_buf) begin
                emit = 1'b1;
                stat = ST_TRUNC;
            end else begin
                n_cnt = cnt1;
                unique case (e_phase)
                    PH_TAG_FIRST: begin
                        n_tag = TAG_W'(b);
                        if (b[4:0] == TAG_NUM_ESC) begin
                            n_phase = PH_TAG_MORE;
                        end else if (b == 8'd0) begin
                            emit = 1'b1;
                            stat = ST_BAD_TAG;
                        end else begin
                            n_phase = PH_LEN_FIRST;
                        end
                    end
                    PH_TAG_MORE: begin
                        if (e_tnum == '0 && b[6:0] == 7'd0) begin
                            // leading zero group
                            emit = 1'b1;
                            stat = ST_BAD_TAG;
                        end else begin
                            n_tag  = {e_tag[TAG_W-9:0], b};
                            n_tnum = tnum_sh;
                            if (!b[7]) begin
                                if (tnum_sh < TNW'(TAG_NUM_MIN)) begin
                                    emit = 1'b1;
                                    stat = ST_BAD_TAG;
                                end else begin
                                    n_phase = PH_LEN_FIRST;
                                end
                            end else if (cnt1 >= HDR_W'(MAX_TAG_OCTETS)) begin
                                // no terminator within the allowed octets
                                emit = 1'b1;
                                stat = ST_BAD_TAG;
                            end
                        end
                    end
                    PH_LEN_FIRST: begin
                        if (b == LEN_INDEF || b == LEN_RESERVED) begin
                            emit = 1'b1;
                            stat = ST_BAD_LEN;
                        end else if (!b[7]) begin
                            fin_len   = LEN_W'(b);
                            n_len     = fin_len;
                            do_finish = 1'b1;
                        end else if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
                            emit = 1'b1;
                            stat = ST_BAD_LEN;
                        end else begin
                            n_left  = 4'(b[6:0]);
                            n_len   = '0;
                            n_phase = PH_LEN_MORE;
                        end
                    end
                    PH_LEN_MORE: begin
                        if (e_len == '0 && b == 8'd0) begin
                            emit = 1'b1;
                            stat = ST_BAD_LEN;
                        end else if (e_len == '0 && e_left == 4'd1 && !b[7]) begin
                            // one-octet long form that fits short form
                            emit = 1'b1;
                            stat = ST_BAD_LEN;
                        end else begin
                            n_len  = len_sh;
                            n_left = left1;
                            if (left1 == 4'd0) begin
                                if (len_sh == '1) begin
                                    emit = 1'b1;
                                    stat = ST_BAD_LEN;
                                end else begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        if (do_finish) begin
            emit = 1'b1;
            stat = (fin_len > LEN_W'(room)) ? ST_OVERRUN : ST_OK;
        end
        if (emit) begin
            n_phase = PH_IDLE;
        end

        o_emit = i_step && emit;
        o_result.status = stat;
        if (stat == ST_OK || stat == ST_OVERRUN) begin
            o_result.tag_value      = e_tag;
            o_result.content_length = fin_len;
            o_result.header_octets  = cnt1;
        end else begin
            o_result.tag_value      = '0;
            o_result.content_length = '0;
            o_result.header_octets  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tag   <= '0;
            r_tnum  <= '0;
            r_cnt   <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_buf   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_tnum  <= n_tnum;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_left  <= n_left;
            r_buf   <= n_buf;
        end
    end

endmodule

[rtl/dtl_out_reg.sv]
// Result register: holds one decoded header until the downstream side takes it.
// Depends on dtl_pkg.
module dtl_out_reg
    import dtl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/der_tag_length_decoder.sv]
// Top level of the ASN.1 DER tag-length header decoder.
// Depends on dtl_pkg, dtl_in_reg, dtl_parser, dtl_out_reg and the assertion header.
//
// Octets of a DER header stream in one beat per cycle; tuser marks the first octet of a
// header and tdata carries the octet and the buffer size. One result beat is given per
// header: when it completes, or at the first octet that shows it bad. The parser takes
// one octet per step, so a beat is accepted every cycle but for stalls; the closing beat is
// held in the input register and its result in the result register. The input stalls
// only while a result waits in the result register and the downstream side is not ready.
`include "der_tag_length_decoder_assert.svh"
module der_tag_length_decoder
    import dtl_pkg::*;
#(
    parameter int MAX_TAG_OCTETS    = DTL_MAX_TAG_OCTETS,
    parameter int MAX_LENGTH_OCTETS = DTL_MAX_LENGTH_OCTETS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // data_byte [7:0], available [39:8]
    input  logic                 i_s_tuser,   // start_req
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // tag_value [31:0], content_length [95:32],
                                              // header_octets [99:96], zero pad [103:100]
    output logic [STAT_W-1:0]    o_m_tuser    // status
);

    t_in_beat s_beat;
    t_in_beat q_beat;
    logic     q_valid;
    logic     out_free;
    logic     step;
    logic     emit;
    t_result  res;
    t_result  m_res;

    assign s_beat.data_byte = i_s_tdata[BYTE_W-1:0];
    assign s_beat.available = i_s_tdata[S_TDATA_W-1:BYTE_W];
    assign s_beat.start_req = i_s_tuser;

    // the parser steps only when a result, if any, has somewhere to go
    assign step = q_valid && out_free;

    dtl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_beat  (s_beat),
        .i_take  (step),
        .o_valid (q_valid),
        .o_beat  (q_beat)
    );

    dtl_parser #(
        .MAX_TAG_OCTETS    (MAX_TAG_OCTETS),
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (q_beat),
        .o_emit   (emit),
        .o_result (res)
    );

    dtl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (res),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_free   (out_free),
        .o_result (m_res)
    );

    assign o_m_tdata = {(M_TDATA_W - M_FIELD_W)'(0), m_res.header_octets,
                        m_res.content_length, m_res.tag_value};
    assign o_m_tuser = m_res.status;

    `DTL_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_s_tready,
        o_m_tvalid && !i_m_tready, "input stalled without a blocked result")
    `DTL_ASSERT_NEXT(a_held_beat, i_clk, i_rst_n, q_valid && !step,
        q_valid && $stable(q_beat), "held input beat lost or changed")
    `DTL_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        o_m_tvalid && (m_res.status == ST_BAD_TAG || m_res.status == ST_BAD_LEN ||
        m_res.status == ST_TRUNC),
        m_res.tag_value == '0 && m_res.content_length == '0 && m_res.header_octets == '0,
        "error result carries header fields")
    `DTL_ASSERT_NOW(a_ok_size, i_clk, i_rst_n,
        o_m_tvalid && (m_res.status == ST_OK || m_res.status == ST_OVERRUN),
        m_res.header_octets >= HDR_W'(2), "decoded header shorter than two octets")

endmodule
